/* sv/i2cee_pkg.sv */
// ----------------------------------------------------------------------------
// I2C EEPROM sequencer package
// Operation and bus command codes, the result word type and its builder.
// ----------------------------------------------------------------------------
package i2cee_pkg;

  // input operations
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_DONE  = 2'd2;

  // bus commands
  localparam logic [2:0] CMD_START     = 3'd0;
  localparam logic [2:0] CMD_SEND      = 3'd1;
  localparam logic [2:0] CMD_RECV_ACK  = 3'd2;
  localparam logic [2:0] CMD_RECV_NACK = 3'd3;
  localparam logic [2:0] CMD_STOP      = 3'd4;
  localparam logic [2:0] CMD_WAIT      = 3'd5;
  localparam logic [2:0] CMD_DONE      = 3'd6;

  // clears the read bit of the control byte
  localparam logic [7:0] CTRL_WR_MASK = 8'hfe;

  // most result words one input word can cause
  localparam int unsigned MAX_RES = 3;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] tx;
    logic [7:0] data;
    logic       dvalid;
    logic       status;
    logic       last;
  } res_t;

  function automatic res_t mk_res(input logic [2:0] cmd, input logic [7:0] tx,
                                  input logic [7:0] data, input logic dvalid,
                                  input logic status);
    res_t r;
    r.cmd    = cmd;
    r.tx     = tx;
    r.data   = data;
    r.dvalid = dvalid;
    r.status = status;
    r.last   = 1'b0;
    return r;
  endfunction

endpackage

/* sv/i2cee_burst.sv */
// ----------------------------------------------------------------------------
// I2C EEPROM sequencer result stage
// Holds up to three result words of one input word and hands them out in
// order; takes a new group when empty or as the last held word leaves.
// ----------------------------------------------------------------------------
module i2cee_burst import i2cee_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic [1:0]          load_cnt,
  input  res_t [MAX_RES-1:0]  load_ent,
  input  logic                out_stall,
  output logic                ready,
  output logic                out_valid,
  output res_t                out_ent
);

  logic [1:0]         cnt_r;
  res_t [MAX_RES-1:0] ent_r;
  logic               pop;

  assign pop       = (cnt_r != 2'd0) && !out_stall;
  assign ready     = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop);
  assign out_valid = (cnt_r != 2'd0);
  assign out_ent   = ent_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= load_cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // shift toward the head on each pop
  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= load_ent;
    end else if (pop) begin
      ent_r[0] <= ent_r[1];
      ent_r[1] <= ent_r[2];
    end
  end

endmodule

/* sv/i2c_eeprom_transaction_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// I2C EEPROM transaction sequencer
// Byte-level master sequencer for serial EEPROM random read and write.
// ----------------------------------------------------------------------------
// Usage: preload write data with load words, then send a start word carrying
// control byte, memory address and count. The block answers with bus commands
// (start, send, receive with ack or nack, stop, write wait, done); feed back a
// completion word after every send or receive command with the ack and the
// received byte. Rate: one input word per clock. A word goes into an input
// register, the sequencer decodes it combinationally against the held
// transaction state and drops up to three result words into the result
// stage; the next word is taken in the same edge as long as the result stage
// can take its group, so the output side sets the pace when words cause
// several results. The write buffer is a memory with one write port and a
// registered read port; the next data byte is prefetched from it every cycle,
// so a send after a completion need not wait for the buffer read. The buffer
// has no reset: reading entries that were never loaded gives unspecified data.
// wide_address resets to 1 (two address bytes).
// ----------------------------------------------------------------------------
module i2c_eeprom_transaction_sequencer_unit import i2cee_pkg::*; #(
  parameter int unsigned MAX_ATTEMPTS = 8,
  parameter int unsigned BUFFER_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_control_byte,
  input  logic [15:0] in_mem_address,
  input  logic [7:0]  in_byte_count,
  input  logic [7:0]  in_write_byte,
  input  logic        in_ack_received,
  input  logic [7:0]  in_read_byte,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_bus_command,
  output logic [7:0]  out_tx_byte,
  output logic [7:0]  out_data_out,
  output logic        out_data_valid,
  output logic        out_status,
  output logic        out_last,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_wide_address
);

  localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  typedef enum logic [2:0] {
    PH_IDLE, PH_CTRL_W, PH_ADDR_HI, PH_ADDR_LO,
    PH_DATA_W, PH_CTRL_R, PH_RECV, PH_RECV_LAST
  } phase_t;

  // buffer pointer follows byte_index modulo the depth; it restarts with
  // byte_index when that wraps past 255
  function automatic logic [AW-1:0] ptr_inc(input logic [7:0] bi,
                                            input logic [AW-1:0] p);
    logic [AW-1:0] q;
    if ((bi == 8'hff) || (p == AW'(BUFFER_DEPTH - 1))) begin
      q = '0;
    end else begin
      q = p + 1'b1;
    end
    return q;
  endfunction

  // input register
  logic        in_vld_r;
  logic [1:0]  op_r;
  logic [7:0]  ctrl_in_r;
  logic [15:0] addr_in_r;
  logic [7:0]  cnt_in_r;
  logic [7:0]  wbyte_r;
  logic        ack_r;
  logic [7:0]  rbyte_r;

  // transaction state
  phase_t      phase_r,  phase_nxt;
  logic [3:0]  att_r,    att_nxt;
  logic [7:0]  bi_r,     bi_nxt;
  logic [AW-1:0] ptr_r,  ptr_nxt;
  logic [7:0]  cnt_r,    cnt_nxt;
  logic [7:0]  ctrl_r,   ctrl_nxt;
  logic [15:0] addr_r,   addr_nxt;
  logic        wide_r;

  // write buffer
  logic [7:0]    wbuf_mem [BUFFER_DEPTH];
  logic [7:0]    wbuf_rd_r;
  logic [AW-1:0] rd_addr;
  logic          mem_we;

  // decode results
  res_t [MAX_RES-1:0] res;
  logic [1:0]  res_n;
  logic        fin, fin_st, fin_dv;
  logic [7:0]  fin_data;
  logic        beg;
  logic [7:0]  bi_inc;
  logic [8:0]  bi_inc2;
  logic        proc;
  logic        burst_rdy;
  logic        burst_vld;
  res_t        burst_ent;

  assign cfg_ready = 1'b1;
  assign bi_inc    = bi_r + 8'd1;
  assign bi_inc2   = {1'b0, bi_inc} + 9'd1;

  // take the held word once its result group fits
  assign proc     = in_vld_r && ((res_n == 2'd0) || burst_rdy);
  assign in_stall = in_vld_r && !proc;

  always_comb begin
    phase_nxt = phase_r;
    att_nxt   = att_r;
    bi_nxt    = bi_r;
    ptr_nxt   = ptr_r;
    cnt_nxt   = cnt_r;
    ctrl_nxt  = ctrl_r;
    addr_nxt  = addr_r;
    mem_we    = 1'b0;
    fin       = 1'b0;
    fin_st    = 1'b0;
    fin_dv    = 1'b0;
    fin_data  = 8'd0;
    beg       = 1'b0;
    res_n     = 2'd0;
    for (int k = 0; k < MAX_RES; k++) begin
      res[k] = '0;
    end

    unique case (op_r)
      OP_LOAD: begin
        if (phase_r == PH_IDLE) begin
          mem_we  = 1'b1;
          bi_nxt  = bi_inc;
          ptr_nxt = ptr_inc(bi_r, ptr_r);
        end
      end
      OP_START: begin
        if (phase_r == PH_IDLE) begin
          ctrl_nxt = ctrl_in_r;
          addr_nxt = addr_in_r;
          // a read of zero bytes still reads one
          cnt_nxt  = (ctrl_in_r[0] && (cnt_in_r == 8'd0)) ? 8'd1 : cnt_in_r;
          att_nxt  = 4'(MAX_ATTEMPTS);
          beg      = 1'b1;
        end
      end
      OP_DONE: begin
        case (phase_r)
          PH_IDLE: begin
          end
          PH_RECV: begin
            // advance the index, and the pointer with it, so later loads land
            // where byte_index points
            bi_nxt  = bi_inc;
            ptr_nxt = ptr_inc(bi_r, ptr_r);
            if (bi_inc2 >= {1'b0, cnt_r}) begin
              phase_nxt = PH_RECV_LAST;
              res[0]    = mk_res(CMD_RECV_NACK, 8'd0, rbyte_r, 1'b1, 1'b0);
            end else begin
              res[0]    = mk_res(CMD_RECV_ACK, 8'd0, rbyte_r, 1'b1, 1'b0);
            end
            res_n = 2'd1;
          end
          PH_RECV_LAST: begin
            fin      = 1'b1;
            fin_data = rbyte_r;
            fin_dv   = 1'b1;
          end
          default: begin
            if (!ack_r) begin
              // nack: retry with a fresh start while attempts remain
              att_nxt = att_r - 4'd1;
              if (att_r != 4'd1) begin
                beg = 1'b1;
              end else begin
                fin    = 1'b1;
                fin_st = 1'b1;
              end
            end else begin
              case (phase_r)
                PH_CTRL_W: begin
                  if (wide_r) begin
                    phase_nxt = PH_ADDR_HI;
                    res[0] = mk_res(CMD_SEND, addr_r[15:8], 8'd0, 1'b0, 1'b0);
                  end else begin
                    phase_nxt = PH_ADDR_LO;
                    res[0] = mk_res(CMD_SEND, addr_r[7:0], 8'd0, 1'b0, 1'b0);
                  end
                  res_n = 2'd1;
                end
                PH_ADDR_HI: begin
                  phase_nxt = PH_ADDR_LO;
                  res[0] = mk_res(CMD_SEND, addr_r[7:0], 8'd0, 1'b0, 1'b0);
                  res_n  = 2'd1;
                end
                PH_ADDR_LO: begin
                  if (!ctrl_r[0]) begin
                    if (cnt_r == 8'd0) begin
                      fin = 1'b1;
                    end else begin
                      // byte_index is already zero here; prefetch holds entry 0
                      phase_nxt = PH_DATA_W;
                      bi_nxt    = 8'd0;
                      ptr_nxt   = '0;
                      res[0] = mk_res(CMD_SEND, wbuf_rd_r, 8'd0, 1'b0, 1'b0);
                      res_n  = 2'd1;
                    end
                  end else begin
                    // repeated start, then the full control byte
                    phase_nxt = PH_CTRL_R;
                    res[0] = mk_res(CMD_START, 8'd0, 8'd0, 1'b0, 1'b0);
                    res[1] = mk_res(CMD_SEND, ctrl_r, 8'd0, 1'b0, 1'b0);
                    res_n  = 2'd2;
                  end
                end
                PH_DATA_W: begin
                  bi_nxt  = bi_inc;
                  ptr_nxt = ptr_inc(bi_r, ptr_r);
                  if (bi_inc >= cnt_r) begin
                    fin = 1'b1;
                  end else begin
                    res[0] = mk_res(CMD_SEND, wbuf_rd_r, 8'd0, 1'b0, 1'b0);
                    res_n  = 2'd1;
                  end
                end
                PH_CTRL_R: begin
                  bi_nxt  = 8'd0;
                  ptr_nxt = '0;
                  if (cnt_r <= 8'd1) begin
                    phase_nxt = PH_RECV_LAST;
                    res[0] = mk_res(CMD_RECV_NACK, 8'd0, 8'd0, 1'b0, 1'b0);
                  end else begin
                    phase_nxt = PH_RECV;
                    res[0] = mk_res(CMD_RECV_ACK, 8'd0, 8'd0, 1'b0, 1'b0);
                  end
                  res_n = 2'd1;
                end
                default: begin
                  phase_nxt = PH_IDLE;
                end
              endcase
            end
          end
        endcase
      end
      default: begin
      end
    endcase

    // start of an attempt: start plus control byte with the read bit cleared
    if (beg) begin
      phase_nxt = PH_CTRL_W;
      bi_nxt    = 8'd0;
      ptr_nxt   = '0;
      res[0] = mk_res(CMD_START, 8'd0, 8'd0, 1'b0, 1'b0);
      res[1] = mk_res(CMD_SEND, ctrl_nxt & CTRL_WR_MASK, 8'd0, 1'b0, 1'b0);
      res_n  = 2'd2;
    end

    // end of transaction: stop, write wait after writes, done
    if (fin) begin
      phase_nxt = PH_IDLE;
      res[0] = mk_res(CMD_STOP, 8'd0, fin_data, fin_dv, 1'b0);
      if (!ctrl_r[0]) begin
        res[1] = mk_res(CMD_WAIT, 8'd0, 8'd0, 1'b0, 1'b0);
        res[2] = mk_res(CMD_DONE, 8'd0, 8'd0, 1'b0, fin_st);
        res_n  = 2'd3;
      end else begin
        res[1] = mk_res(CMD_DONE, 8'd0, 8'd0, 1'b0, fin_st);
        res_n  = 2'd2;
      end
    end

    for (int k = 0; k < MAX_RES; k++) begin
      res[k].last = (2'(k + 1) == res_n);
    end
  end

  // input register: refill as the held word is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_r      <= in_operation;
      ctrl_in_r <= in_control_byte;
      addr_in_r <= in_mem_address;
      cnt_in_r  <= in_byte_count;
      wbyte_r   <= in_write_byte;
      ack_r     <= in_ack_received;
      rbyte_r   <= in_read_byte;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      att_r   <= 4'd0;
      bi_r    <= 8'd0;
      ptr_r   <= '0;
      cnt_r   <= 8'd0;
      ctrl_r  <= 8'd0;
      addr_r  <= 16'd0;
      wide_r  <= 1'b1;
    end else begin
      if (proc) begin
        phase_r <= phase_nxt;
        att_r   <= att_nxt;
        bi_r    <= bi_nxt;
        ptr_r   <= ptr_nxt;
        cnt_r   <= cnt_nxt;
        ctrl_r  <= ctrl_nxt;
        addr_r  <= addr_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        wide_r <= cfg_wide_address;
      end
    end
  end

  // prefetch the byte the next send will need: entry byte_index + 1 while
  // sending data, entry byte_index (zero) before the first data byte
  always_comb begin
    if (proc) begin
      rd_addr = (phase_nxt == PH_DATA_W) ? ptr_inc(bi_nxt, ptr_nxt) : ptr_nxt;
    end else begin
      rd_addr = (phase_r == PH_DATA_W) ? ptr_inc(bi_r, ptr_r) : ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && mem_we) begin
      wbuf_mem[ptr_r] <= wbyte_r;
    end
  end

  always_ff @(posedge clk) begin
    wbuf_rd_r <= wbuf_mem[rd_addr];
  end

  i2cee_burst u_burst (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (proc && (res_n != 2'd0)),
    .load_cnt  (res_n),
    .load_ent  (res),
    .out_stall (out_stall),
    .ready     (burst_rdy),
    .out_valid (burst_vld),
    .out_ent   (burst_ent)
  );

  assign out_valid       = burst_vld;
  assign out_bus_command = burst_ent.cmd;
  assign out_tx_byte     = burst_ent.tx;
  assign out_data_out    = burst_ent.data;
  assign out_data_valid  = burst_ent.dvalid;
  assign out_status      = burst_ent.status;
  assign out_last        = burst_ent.last;

`ifndef NO_ASSERTIONS
  // a busy transaction always has an attempt in hand
  a_att_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |-> (att_r != 4'd0))
    else $error("busy with no attempts left");

  // a held input word is never dropped while it waits
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !proc) |=> in_vld_r)
    else $error("held input word lost");

  // receive phases belong to read transactions only
  a_recv_rd: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PH_RECV) || (phase_r == PH_RECV_LAST)) |-> ctrl_r[0])
    else $error("receive phase in a write transaction");

  // data sends belong to nonempty write transactions only
  a_data_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA_W) |-> (!ctrl_r[0] && (cnt_r != 8'd0)))
    else $error("data phase outside a nonempty write");
`endif

endmodule
